// ===== src/ttrc_pkg.sv =====
// Package with the shared types, constants and modulo fold of the recurrence checksum unit.
package ttrc_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned TERM_W  = 16;
    localparam int unsigned PROD_W  = 25;

    localparam logic [TERM_W-1:0] SEED_OFFSET = 16'd7;
    localparam logic [TERM_W-1:0] TERM_ONE    = 16'd1;
    localparam logic [BYTE_W-1:0] INDEX_ONE   = 8'd1;
    localparam logic [TERM_W:0]   FOLD_MOD    = 17'd65535;
    localparam logic [TERM_W:0]   FOLD_BASE   = 17'd65536;

    // One accepted message byte with its framing marks.
    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              first_byte;
        logic              last_byte;
    } t_item;

    // Reduces a 25-bit value modulo 65535 by adding the high and low halves.
    function automatic logic [TERM_W-1:0] fold_mod(input logic [PROD_W-1:0] x);
        logic [TERM_W:0] s;
        s = {8'd0, x[PROD_W-1:TERM_W]} + {1'b0, x[TERM_W-1:0]};
        if (s >= FOLD_MOD) begin
            s = s - FOLD_MOD;
        end
        return s[TERM_W-1:0];
    endfunction

endpackage

// ===== src/ttrc_in_reg.sv =====
// Input register stage that holds one accepted byte until the core takes it.
module ttrc_in_reg (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  ttrc_pkg::t_item i_item,
    input  logic           i_take,
    output logic           o_valid,
    output ttrc_pkg::t_item o_item
);

    logic            r_valid;
    ttrc_pkg::t_item r_item;

    // The slot is free when empty or when its byte leaves in this cycle.
    assign o_ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ===== src/ttrc_core.sv =====
// Recurrence state registers and the combinational next-term logic.
module ttrc_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_advance,
    input  ttrc_pkg::t_item                i_item,
    output logic [ttrc_pkg::TERM_W-1:0]    o_term_next
);

    logic [ttrc_pkg::TERM_W-1:0] r_term_prev, n_term_prev;
    logic [ttrc_pkg::TERM_W-1:0] r_term_curr, n_term_curr;
    logic [ttrc_pkg::BYTE_W-1:0] r_byte_index, n_byte_index;

    logic [ttrc_pkg::BYTE_W-1:0] alpha;
    logic [ttrc_pkg::BYTE_W-1:0] beta;
    logic [ttrc_pkg::BYTE_W:0]   factor;
    logic [ttrc_pkg::PROD_W-1:0] prod_a;
    logic [ttrc_pkg::PROD_W-1:0] prod_b;
    logic                        a_ge_b;
    logic [ttrc_pkg::PROD_W-1:0] mag;
    logic [ttrc_pkg::TERM_W-1:0] mag_mod;
    logic [ttrc_pkg::TERM_W:0]   wrap;
    logic [ttrc_pkg::TERM_W-1:0] term_new;

    // 17*i and 31*i modulo 256 as shift-and-add on the 8-bit index.
    assign alpha  = r_byte_index + {r_byte_index[3:0], 4'd0};
    assign beta   = {r_byte_index[2:0], 5'd0} - r_byte_index;
    assign factor = {1'b0, i_item.data_byte} + {1'b0, alpha};
    assign prod_a = factor * r_term_curr;
    assign prod_b = {{(ttrc_pkg::PROD_W-ttrc_pkg::BYTE_W){1'b0}}, beta}
                  * {{(ttrc_pkg::PROD_W-ttrc_pkg::TERM_W){1'b0}}, r_term_prev};
    assign a_ge_b = prod_a >= prod_b;
    assign mag    = a_ge_b ? (prod_a - prod_b) : (prod_b - prod_a);
    assign mag_mod = ttrc_pkg::fold_mod(mag);

    // When the difference is negative the result is (1 - |A-B|) mod 65535.
    always_comb begin
        wrap = ttrc_pkg::FOLD_BASE - {1'b0, mag_mod};
        if (wrap >= ttrc_pkg::FOLD_MOD) begin
            wrap = wrap - ttrc_pkg::FOLD_MOD;
        end
        term_new = a_ge_b ? mag_mod : wrap[ttrc_pkg::TERM_W-1:0];
    end

    always_comb begin
        if (i_item.first_byte) begin
            n_term_prev  = ttrc_pkg::TERM_ONE;
            n_term_curr  = {8'd0, i_item.data_byte} + ttrc_pkg::SEED_OFFSET;
            n_byte_index = ttrc_pkg::INDEX_ONE;
        end else begin
            n_term_prev  = r_term_curr;
            n_term_curr  = term_new;
            n_byte_index = r_byte_index + ttrc_pkg::INDEX_ONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_term_prev  <= ttrc_pkg::TERM_ONE;
            r_term_curr  <= ttrc_pkg::TERM_ONE;
            r_byte_index <= '0;
        end else if (i_advance) begin
            r_term_prev  <= n_term_prev;
            r_term_curr  <= n_term_curr;
            r_byte_index <= n_byte_index;
        end
    end

    assign o_term_next = n_term_curr;

endmodule

// ===== src/ttrc_out_reg.sv =====
// Result register that holds a checksum until the downstream side takes it.
module ttrc_out_reg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_load,
    input  logic [ttrc_pkg::TERM_W-1:0] i_checksum,
    input  logic                        i_ready,
    output logic                        o_free,
    output logic                        o_valid,
    output logic [ttrc_pkg::TERM_W-1:0] o_checksum
);

    logic                        r_valid;
    logic [ttrc_pkg::TERM_W-1:0] r_checksum;

    assign o_free = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_checksum <= i_checksum;
        end
    end

    assign o_valid    = r_valid;
    assign o_checksum = r_checksum;

endmodule

// ===== src/three_term_recurrence_checksum_unit.sv =====
// Top level of the three-term recurrence checksum unit.
//
// This unit takes one message byte per transfer on the slave side and, for every byte marked
// with tlast, returns the 16-bit checksum of the message as one transfer on the master side.
// A byte with tuser set starts a new message: the previous term becomes 1, the current term
// becomes byte+7 and the byte index becomes 1. Every later byte at index i forms
// A = (byte + 17i mod 256) * current and B = (31i mod 256) * previous, and the new term is
// (A-B) mod 65535, or (A-B+1) mod 65535 taken non-negative when A is below B. Bytes sent
// before any start mark, or after a last byte without a new start mark, simply continue the
// recurrence from the state left behind. A byte passes through an input register and then
// through the combinational next-term logic (two small multipliers and a fold modulo 65535)
// that updates the state registers, so the unit takes one byte in every clock cycle unless it
// stalls. A checksum is loaded into the result register as its last byte leaves the input
// register, and is offered on the master side from that register. The unit stalls
// only when a checksum is waiting in the result register, the master side holds tready low,
// and the byte held in the input register is itself a last byte.
module three_term_recurrence_checksum_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Slave side: message bytes.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] first_byte
    input  logic        s_tlast,   // last_byte
    // Master side: checksums.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [15:0] checksum
);

    ttrc_pkg::t_item             in_item;
    ttrc_pkg::t_item             core_item;
    logic                        core_valid;
    logic                        out_free;
    logic                        advance;
    logic                        load_result;
    logic [ttrc_pkg::TERM_W-1:0] term_next;

    assign in_item.data_byte  = s_tdata;
    assign in_item.first_byte = s_tuser;
    assign in_item.last_byte  = s_tlast;

    // A byte leaves the input register for the core unless it would produce a checksum
    // while the result register still holds one that the master side does not take.
    assign advance     = core_valid && (!core_item.last_byte || out_free);
    assign load_result = advance && core_item.last_byte;

    ttrc_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_tvalid),
        .o_ready (s_tready),
        .i_item  (in_item),
        .i_take  (advance),
        .o_valid (core_valid),
        .o_item  (core_item)
    );

    ttrc_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_advance   (advance),
        .i_item      (core_item),
        .o_term_next (term_next)
    );

    ttrc_out_reg u_out_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (load_result),
        .i_checksum (term_next),
        .i_ready    (m_tready),
        .o_free     (out_free),
        .o_valid    (m_tvalid),
        .o_checksum (m_tdata)
    );

endmodule

// ===== test/three_term_recurrence_checksum_unit_tb.sv =====
// Self-checking testbench for the three-term recurrence checksum unit.
module three_term_recurrence_checksum_unit_tb;

    // Step sizes of the two index-dependent multipliers of the recurrence.
    localparam int unsigned ALPHA_STEP  = 17;
    localparam int unsigned BETA_STEP   = 31;
    // Byte budget for the whole run, and the cycle count at which a hung run is abandoned.
    localparam int unsigned BYTE_TARGET = 950;
    localparam int unsigned CYCLE_LIMIT = 200000;
    // Length of the deliberate receiver hold-off, in cycles.
    localparam int unsigned HOLD_CYCLES = 300;
    // Message length that carries the byte index past its wrap at 256.
    localparam int unsigned WRAP_LEN    = 300;

    // Tracks the recurrence terms of the unit and holds the checksums still owed by it.
    class checksum_scoreboard;
        logic [ttrc_pkg::TERM_W-1:0] term_prev;
        logic [ttrc_pkg::TERM_W-1:0] term_curr;
        logic [ttrc_pkg::BYTE_W-1:0] byte_index;
        logic [ttrc_pkg::TERM_W-1:0] checksums_due[$];
        int unsigned                 mismatches;

        function new();
            term_prev  = ttrc_pkg::TERM_ONE;
            term_curr  = ttrc_pkg::TERM_ONE;
            byte_index = '0;
            mismatches = 0;
        endfunction

        // Next term for a later byte: (A - B) mod 65535, or (A - B + 1) mod 65535 when
        // A is below B, since the original arithmetic wraps through 2^64.
        function logic [ttrc_pkg::TERM_W-1:0] next_term(logic [ttrc_pkg::BYTE_W-1:0] data);
            longint unsigned alpha, beta, a_prod, b_prod, gap;
            alpha  = (longint'(byte_index) * ALPHA_STEP) % 256;
            beta   = (longint'(byte_index) * BETA_STEP) % 256;
            a_prod = (longint'(data) + alpha) * longint'(term_curr);
            b_prod = beta * longint'(term_prev);
            if (a_prod >= b_prod) begin
                return ttrc_pkg::TERM_W'((a_prod - b_prod) % longint'(ttrc_pkg::FOLD_MOD));
            end
            gap = (b_prod - a_prod) % longint'(ttrc_pkg::FOLD_MOD);
            return ttrc_pkg::TERM_W'((1 + longint'(ttrc_pkg::FOLD_MOD) - gap)
                                     % longint'(ttrc_pkg::FOLD_MOD));
        endfunction

        // Takes in one accepted byte and queues its checksum when it closes a message.
        function void note_byte(ttrc_pkg::t_item item);
            logic [ttrc_pkg::TERM_W-1:0] fresh;
            if (item.first_byte) begin
                term_prev  = ttrc_pkg::TERM_ONE;
                term_curr  = ttrc_pkg::TERM_W'(item.data_byte) + ttrc_pkg::SEED_OFFSET;
                byte_index = ttrc_pkg::INDEX_ONE;
            end else begin
                fresh      = next_term(item.data_byte);
                term_prev  = term_curr;
                term_curr  = fresh;
                byte_index = byte_index + ttrc_pkg::INDEX_ONE;
            end
            if (item.last_byte) begin
                checksums_due.push_back(term_curr);
            end
        endfunction

        // Compares one checksum transfer with the oldest checksum owed.
        function void check_checksum(logic [ttrc_pkg::TERM_W-1:0] got);
            logic [ttrc_pkg::TERM_W-1:0] want;
            if (checksums_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected checksum transfer: checksum 0x%04h", got);
                end
                return;
            end
            want = checksums_due.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("checksum mismatch: expected 0x%04h, actual 0x%04h", want, got);
                end
            end
        endfunction

        function int unsigned pending();
            return checksums_due.size();
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] data_byte
    logic        s_tuser;   // [0] first_byte
    logic        s_tlast;   // last_byte
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // [15:0] checksum

    checksum_scoreboard sb = new();

    int unsigned cycle_count = 0;
    int unsigned bytes_sent;
    // Sender-side pacing: a steady stretch sends back to back, a burst forces it.
    bit          tx_steady;
    int unsigned tx_run_left;
    bit          burst_on;
    // Raised by the stimulus to ask the receiver for one long hold-off.
    bit          hold_off_req;

    three_term_recurrence_checksum_unit u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        i_clk        = 1'b0;
        i_rst_n      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = 1'b0;
        s_tlast      = 1'b0;
        m_tready     = 1'b0;
        bytes_sent   = 0;
        tx_steady    = 1'b0;
        tx_run_left  = 0;
        burst_on     = 1'b0;
        hold_off_req = 1'b0;
    end

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // A run that has not finished by the cycle limit has hung somewhere.
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("three_term_recurrence_checksum_unit regression: fail");
        $finish;
    end

    // Every checksum transfer is checked at the rising edge on which it happens.
    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) begin
            sb.check_checksum(m_tdata);
        end
    end

    // Receiver. Before each transfer it waits a random number of cycles with tready low,
    // except in steady stretches where it stays ready. Once, on request, it holds tready
    // low for a long stretch so that results back up and the slave side stalls.
    initial begin
        int unsigned wait_cycles;
        int unsigned run_left;
        bit          rx_steady;
        run_left  = 0;
        rx_steady = 1'b0;
        wait (i_rst_n);
        @(negedge i_clk);
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            if (run_left == 0) begin
                rx_steady = ($urandom_range(0, 3) == 0);
                run_left  = $urandom_range(10, 40);
            end
            run_left--;
            wait_cycles = rx_steady ? 0 : $urandom_range(0, 14);
            if (wait_cycles != 0) begin
                m_tready <= 1'b0;
                repeat (wait_cycles) @(negedge i_clk);
            end
            m_tready <= 1'b1;
            do @(posedge i_clk); while (!m_tvalid);
            @(negedge i_clk);
        end
    end

    // Offers one byte after a random gap and returns at the falling edge after its transfer.
    task automatic send_byte(input logic [7:0] data, input logic is_first, input logic is_last);
        int unsigned     gap;
        ttrc_pkg::t_item item;
        if (tx_run_left == 0) begin
            tx_steady   = ($urandom_range(0, 3) == 0);
            tx_run_left = $urandom_range(10, 40);
        end
        tx_run_left--;
        gap = (tx_steady || burst_on) ? 0 : $urandom_range(0, 14);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= is_first;
        s_tlast  <= is_last;
        do @(posedge i_clk); while (!s_tready);
        item.data_byte  = data;
        item.first_byte = is_first;
        item.last_byte  = is_last;
        sb.note_byte(item);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    // Random message content, leaning a little towards the two extreme byte values.
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 9))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Sends a message of the given length with random content, marked at either end as asked.
    task automatic send_message(input int unsigned len, input bit marked_first,
                                input bit marked_last);
        for (int unsigned k = 0; k < len; k++) begin
            send_byte(pick_byte(), marked_first && (k == 0), marked_last && (k == len - 1));
        end
    endtask

    initial begin
        int unsigned kind;
        bit          pressure_done;
        bit          wrap_done;
        pressure_done = 1'b0;
        wrap_done     = 1'b0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Bytes straight after reset with no start mark run on from the reset terms, starting at index 0.
        send_byte(8'h00, 1'b0, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b1);
        // Single-byte messages at both ends of the byte range give 7 and 262.
        send_byte(8'h00, 1'b1, 1'b1);
        send_byte(8'hFF, 1'b1, 1'b1);
        // A byte after a last byte, with no new start mark, carries the recurrence on.
        send_byte(8'h5A, 1'b0, 1'b1);
        // All-ones content drives A towards its largest value.
        send_byte(8'hFF, 1'b1, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b1);
        // All-zero content keeps A small, so B often exceeds it and the wrap correction applies.
        send_byte(8'h00, 1'b1, 1'b0);
        send_byte(8'h00, 1'b0, 1'b0);
        send_byte(8'h00, 1'b0, 1'b0);
        send_byte(8'h00, 1'b0, 1'b1);
        // A start mark in the middle of a message restarts it without any checksum.
        send_byte(8'h12, 1'b1, 1'b0);
        send_byte(8'h34, 1'b0, 1'b0);
        send_byte(8'h56, 1'b1, 1'b0);
        send_byte(8'hA5, 1'b0, 1'b0);
        send_byte(8'h81, 1'b0, 1'b1);

        // Random part: mostly well-formed messages of random length, a few long enough for the
        // byte index to wrap, and some unmarked or wrongly marked noise.
        while (bytes_sent < BYTE_TARGET) begin
            if (!pressure_done && bytes_sent >= 400) begin
                // Back-to-back single-byte messages during a long receiver hold-off fill the
                // result path, so the slave side has to stall.
                pressure_done = 1'b1;
                hold_off_req  = 1'b1;
                burst_on      = 1'b1;
                repeat (60) send_byte(pick_byte(), 1'b1, 1'b1);
                burst_on      = 1'b0;
            end else if (!wrap_done && bytes_sent >= 600) begin
                wrap_done = 1'b1;
                send_message(WRAP_LEN, 1'b1, 1'b1);
            end else begin
                kind = $urandom_range(0, 39);
                if (kind < 24) begin
                    send_message($urandom_range(1, 8), 1'b1, 1'b1);
                end else if (kind < 34) begin
                    send_message($urandom_range(9, 40), 1'b1, 1'b1);
                end else if (kind == 34) begin
                    send_message($urandom_range(257, 280), 1'b1, 1'b1);
                end else if (kind < 37) begin
                    // Broken framing: a message that never closes, or one without a start.
                    send_message($urandom_range(1, 10), kind == 35, kind == 36);
                end else begin
                    repeat ($urandom_range(1, 6)) begin
                        send_byte(pick_byte(), $urandom_range(0, 3) == 0,
                                  $urandom_range(0, 3) == 0);
                    end
                end
            end
        end
        s_tvalid <= 1'b0;

        // Drain every checksum still owed, then leave a margin for anything stray.
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("three_term_recurrence_checksum_unit regression: pass");
        end else begin
            $display("three_term_recurrence_checksum_unit regression: fail");
        end
        $finish;
    end

endmodule
